[rtl/cfvg_pkg.sv]
// ---------------------------------------------------------------------------
// Circle fan vertex generator package
// Shared widths, constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package cfvg_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int IDX_W      = 13;
    localparam int SEG_W      = 13;
    localparam int RAD_W      = 16;
    localparam int OUT_W      = 17;
    localparam int TRIG_W     = 18;
    localparam int CORDIC_N   = 30;
    localparam int XY_W       = 34;
    localparam int Z_W        = 33;
    localparam int SHIFT_IN   = 32 - ANGLE_BITS;

    localparam logic [XY_W-1:0]  CORDIC_X0  = XY_W'(652032874);
    localparam logic [SEG_W-1:0] SEG_MIN    = SEG_W'(3);
    localparam logic [SEG_W-1:0] SEG_RESET  = SEG_W'(64);
    localparam logic [RAD_W-1:0] RAD_RESET  = RAD_W'(256);
    localparam logic [4:0]       GREEN_MULT = 5'd20;
    localparam logic [OUT_W-1:0] ONE_Q16    = OUT_W'(65536);
    localparam logic [OUT_W-1:0] POS_LIM    = OUT_W'(65535);

    localparam logic [1:0] REG_SEGMENTS   = 2'd0;
    localparam logic [1:0] REG_RADIUS     = 2'd1;
    localparam logic [1:0] REG_WHITE_MODE = 2'd2;

    typedef struct packed {
        logic valid;
        logic center;
    } pipe_tag_t;

    function automatic logic [Z_W-1:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return {1'b0, v};
    endfunction

endpackage

[rtl/circle_fan_vertex_generator.sv]
// ---------------------------------------------------------------------------
// Circle fan vertex generator
// Returns position and color of one triangle fan vertex per request.
// ---------------------------------------------------------------------------
// The block accepts one vertex request per cycle while the result side is not
// stalled and returns one result per request, in order. Each request passes
// through the bit-per-stage remainder and phase division, the CORDIC stages,
// the multiplier register and the output register. A stall on the
// result side holds the whole pipeline. Configuration writes are taken at
// any time but must only be issued while no request is in flight.
module circle_fan_vertex_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // vertex_index[12:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // pos_x, pos_y, color_red, color_green, color_blue
);

    localparam int AB = cfvg_pkg::ANGLE_BITS;
    localparam int TW = cfvg_pkg::TRIG_W;
    localparam int OW = cfvg_pkg::OUT_W;
    localparam int PW = 2 * TW;

    logic [cfvg_pkg::SEG_W-1:0] segments_reg;
    logic [cfvg_pkg::RAD_W-1:0] radius_reg;
    logic                       white_reg;
    logic [cfvg_pkg::SEG_W-1:0] seg_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segments_reg <= cfvg_pkg::SEG_RESET;
            radius_reg   <= cfvg_pkg::RAD_RESET;
            white_reg    <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                cfvg_pkg::REG_SEGMENTS:   segments_reg <= cfg_data[12:0];
                cfvg_pkg::REG_RADIUS:     radius_reg   <= cfg_data;
                cfvg_pkg::REG_WHITE_MODE: white_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign seg_eff = (segments_reg < cfvg_pkg::SEG_MIN) ? cfvg_pkg::SEG_MIN : segments_reg;

    logic                en;
    logic                m_valid_reg;
    cfvg_pkg::pipe_tag_t in_tag;
    cfvg_pkg::pipe_tag_t ph_tag;
    logic [AB-1:0]       phase;
    logic [AB-1:0]       phase20;
    logic [AB+4:0]       phase_mul;
    cfvg_pkg::pipe_tag_t c1_tag;
    cfvg_pkg::pipe_tag_t c2_tag;
    logic signed [TW-1:0] cos1;
    logic signed [TW-1:0] sin1;
    logic signed [TW-1:0] cos2;
    logic signed [TW-1:0] sin2;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign in_tag.valid  = s_tvalid;
    assign in_tag.center = (s_tdata[12:0] == '0);

    cfvg_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_tag    (in_tag),
        .in_index  (s_tdata[12:0]),
        .seg       (seg_eff),
        .out_tag   (ph_tag),
        .out_phase (phase)
    );

    assign phase_mul = phase * cfvg_pkg::GREEN_MULT;
    assign phase20   = phase_mul[AB-1:0];

    cfvg_cordic u_cordic_pos (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_tag   (ph_tag),
        .in_phase (phase),
        .out_tag  (c1_tag),
        .out_cos  (cos1),
        .out_sin  (sin1)
    );

    cfvg_cordic u_cordic_green (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_tag   (ph_tag),
        .in_phase (phase20),
        .out_tag  (c2_tag),
        .out_cos  (cos2),
        .out_sin  (sin2)
    );

    cfvg_pkg::pipe_tag_t  mul_tag_reg;
    logic signed [PW-1:0] px_prod_reg;
    logic signed [PW-1:0] py_prod_reg;
    logic signed [PW-1:0] rr_prod_reg;
    logic signed [PW-1:0] gg_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_tag_reg <= '0;
        end else if (en) begin
            mul_tag_reg <= c1_tag;
        end
        if (en) begin
            px_prod_reg <= $signed({2'b00, radius_reg}) * cos1;
            py_prod_reg <= $signed({2'b00, radius_reg}) * sin1;
            rr_prod_reg <= cos1 * cos1;
            gg_prod_reg <= sin2 * sin2;
        end
    end

    function automatic logic [OW-1:0] round_pos(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = (v + PW'(32768)) >>> 16;
        if (r > PW'(65535)) begin
            return cfvg_pkg::POS_LIM;
        end else if (r < -PW'(65535)) begin
            return -cfvg_pkg::POS_LIM;
        end
        return r[OW-1:0];
    endfunction

    function automatic logic [OW-1:0] round_sq(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = (v + PW'(32768)) >>> 16;
        return r[OW-1:0];
    endfunction

    logic [OW-1:0] px_next;
    logic [OW-1:0] py_next;
    logic [OW-1:0] red_next;
    logic [OW-1:0] green_next;
    logic [OW-1:0] blue_next;

    always_comb begin
        px_next    = round_pos(px_prod_reg);
        py_next    = round_pos(py_prod_reg);
        red_next   = round_sq(rr_prod_reg);
        green_next = round_sq(gg_prod_reg);
        blue_next  = '0;
        if (mul_tag_reg.center) begin
            px_next    = '0;
            py_next    = '0;
            red_next   = cfvg_pkg::ONE_Q16;
            green_next = cfvg_pkg::ONE_Q16;
        end
        if (white_reg) begin
            red_next   = cfvg_pkg::ONE_Q16;
            green_next = cfvg_pkg::ONE_Q16;
            blue_next  = cfvg_pkg::ONE_Q16;
        end
    end

    logic [OW-1:0] px_reg;
    logic [OW-1:0] py_reg;
    logic [OW-1:0] red_reg;
    logic [OW-1:0] green_reg;
    logic [OW-1:0] blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mul_tag_reg.valid;
        end
        if (en) begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, blue_reg, green_reg, red_reg, py_reg, px_reg};

    a_tags_match : assert property (@(posedge aclk) disable iff (!aresetn)
        c1_tag == c2_tag) else $error("CORDIC lanes out of step");

    a_red_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (red_reg <= cfvg_pkg::ONE_Q16 && green_reg <= cfvg_pkg::ONE_Q16))
        else $error("color above full scale");

    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

[rtl/cfvg_phase.sv]
// ---------------------------------------------------------------------------
// Phase pipeline
// Bit-per-stage remainder of the index minus one by the segment count, then a
// bit-per-stage division that scales the remainder to a phase.
// ---------------------------------------------------------------------------
module cfvg_phase (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  cfvg_pkg::pipe_tag_t            in_tag,
    input  logic [cfvg_pkg::IDX_W-1:0]     in_index,
    input  logic [cfvg_pkg::SEG_W-1:0]     seg,
    output cfvg_pkg::pipe_tag_t            out_tag,
    output logic [cfvg_pkg::ANGLE_BITS-1:0] out_phase
);

    localparam int NM = cfvg_pkg::IDX_W;
    localparam int ND = cfvg_pkg::ANGLE_BITS;
    localparam int SW = cfvg_pkg::SEG_W;
    localparam int AB = cfvg_pkg::ANGLE_BITS;

    cfvg_pkg::pipe_tag_t  tag_reg  [0:NM+ND];
    logic [SW-1:0]        rem_reg  [0:NM+ND];
    logic [NM-1:0]        num_reg  [0:NM];
    logic [AB-1:0]        quo_reg  [NM:NM+ND];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= in_tag;
        end
        if (en) begin
            rem_reg[0] <= '0;
            num_reg[0] <= in_index - NM'(1);
        end
    end

    genvar j;
    generate
        for (j = 0; j < NM; j++) begin : g_mod
            logic [SW:0]   trial;
            logic          ge;
            logic [SW-1:0] rem_next;
            assign trial    = {rem_reg[j], num_reg[j][NM-1]};
            assign ge       = trial >= {1'b0, seg};
            assign rem_next = ge ? SW'(trial - {1'b0, seg}) : trial[SW-1:0];
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    tag_reg[j+1] <= '0;
                end else if (en) begin
                    tag_reg[j+1] <= tag_reg[j];
                end
                if (en) begin
                    rem_reg[j+1] <= rem_next;
                    num_reg[j+1] <= {num_reg[j][NM-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[NM] <= '0;
            end
        end

        for (j = NM; j < NM + ND; j++) begin : g_div
            logic [SW:0]   trial;
            logic          ge;
            logic [SW-1:0] rem_next;
            assign trial    = {rem_reg[j], 1'b0};
            assign ge       = trial >= {1'b0, seg};
            assign rem_next = ge ? SW'(trial - {1'b0, seg}) : trial[SW-1:0];
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    tag_reg[j+1] <= '0;
                end else if (en) begin
                    tag_reg[j+1] <= tag_reg[j];
                end
                if (en) begin
                    rem_reg[j+1] <= rem_next;
                    quo_reg[j+1] <= {quo_reg[j][AB-2:0], ge};
                end
            end
        end
    endgenerate

    assign out_tag   = tag_reg[NM+ND];
    assign out_phase = quo_reg[NM+ND];

endmodule

[rtl/cfvg_cordic.sv]
// ---------------------------------------------------------------------------
// CORDIC sine and cosine
// Thirty rotation stages in Q2.30, then rounding to Q1.16 and quadrant fold.
// ---------------------------------------------------------------------------
module cfvg_cordic (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  cfvg_pkg::pipe_tag_t             in_tag,
    input  logic [cfvg_pkg::ANGLE_BITS-1:0] in_phase,
    output cfvg_pkg::pipe_tag_t             out_tag,
    output logic signed [cfvg_pkg::TRIG_W-1:0] out_cos,
    output logic signed [cfvg_pkg::TRIG_W-1:0] out_sin
);

    localparam int N  = cfvg_pkg::CORDIC_N;
    localparam int XW = cfvg_pkg::XY_W;
    localparam int ZW = cfvg_pkg::Z_W;
    localparam int AB = cfvg_pkg::ANGLE_BITS;
    localparam int TW = cfvg_pkg::TRIG_W;

    cfvg_pkg::pipe_tag_t     tag_reg  [0:N];
    logic signed [XW-1:0]    x_reg    [0:N];
    logic signed [XW-1:0]    y_reg    [0:N];
    logic signed [ZW-1:0]    z_reg    [0:N];
    logic [1:0]              quad_reg [0:N];
    cfvg_pkg::pipe_tag_t     otag_reg;
    logic signed [TW-1:0]    cos_reg;
    logic signed [TW-1:0]    sin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= in_tag;
        end
        if (en) begin
            x_reg[0]    <= cfvg_pkg::CORDIC_X0;
            y_reg[0]    <= '0;
            z_reg[0]    <= ZW'({in_phase[AB-3:0], {cfvg_pkg::SHIFT_IN{1'b0}}});
            quad_reg[0] <= in_phase[AB-1:AB-2];
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_rot
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic signed [ZW-1:0] ang;
            assign dx  = y_reg[i] >>> i;
            assign dy  = x_reg[i] >>> i;
            assign ang = cfvg_pkg::atan_turn(i);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    tag_reg[i+1] <= '0;
                end else if (en) begin
                    tag_reg[i+1] <= tag_reg[i];
                end
                if (en) begin
                    quad_reg[i+1] <= quad_reg[i];
                    if (!z_reg[i][ZW-1]) begin
                        x_reg[i+1] <= x_reg[i] - dx;
                        y_reg[i+1] <= y_reg[i] + dy;
                        z_reg[i+1] <= z_reg[i] - ang;
                    end else begin
                        x_reg[i+1] <= x_reg[i] + dx;
                        y_reg[i+1] <= y_reg[i] - dy;
                        z_reg[i+1] <= z_reg[i] + ang;
                    end
                end
            end
        end
    endgenerate

    function automatic logic signed [TW-1:0] round_q16(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = (v + XW'(8192)) >>> 14;
        if (r > XW'(65536)) begin
            return TW'(65536);
        end else if (r < -XW'(65536)) begin
            return -TW'(65536);
        end
        return r[TW-1:0];
    endfunction

    logic signed [TW-1:0] cq;
    logic signed [TW-1:0] sq;
    logic signed [TW-1:0] cos_next;
    logic signed [TW-1:0] sin_next;

    always_comb begin
        cq = round_q16(x_reg[N]);
        sq = round_q16(y_reg[N]);
        case (quad_reg[N])
            2'd0: begin
                cos_next = cq;
                sin_next = sq;
            end
            2'd1: begin
                cos_next = -sq;
                sin_next = cq;
            end
            2'd2: begin
                cos_next = -cq;
                sin_next = -sq;
            end
            default: begin
                cos_next = sq;
                sin_next = -cq;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            otag_reg <= '0;
        end else if (en) begin
            otag_reg <= tag_reg[N];
        end
        if (en) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_tag = otag_reg;
    assign out_cos = cos_reg;
    assign out_sin = sin_reg;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Circle fan vertex generator testbench
// Sends vertex requests under several register settings, with random gaps
// and back pressure, and checks every result against a CORDIC predictor.
// ---------------------------------------------------------------------------
module testbench;

    localparam int  LATENCY = 64;
    localparam int  SETTLE  = LATENCY + 10;
    localparam int  LIMIT   = 600000;

    typedef struct {
        logic signed [16:0] pos_x;
        logic signed [16:0] pos_y;
        logic [16:0]        red;
        logic [16:0]        green;
        logic [16:0]        blue;
    } vertex_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;

    vertex_t     vertex_queue[$];
    int          err_cnt;
    int          vertex_cnt;
    int          cfg_cnt;
    int          cycle_cnt;
    bit          idle_on;
    bit          hold_req;

    logic [12:0] segments_reg;
    logic [15:0] radius_reg;
    logic        white_reg;

    longint atan_turn32[30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1
    };

    circle_fan_vertex_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // vertex_index[12:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // pos_x, pos_y, color_red, color_green, color_blue
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("** circle_fan_vertex_generator: FAILED **");
            $finish;
        end
    end

    function automatic longint clamp_to(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Cosine and sine in Q1.16 of a phase given in 2^ANGLE_BITS units per turn.
    function automatic void cordic_sincos(input longint unsigned phase,
                                          output longint c, output longint s);
        logic [31:0] t;
        longint      x, y, z, dx, dy, cq, sq;
        t = 32'(phase << (32 - cfvg_pkg::ANGLE_BITS));
        z = longint'(t[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - atan_turn32[i];
            end else begin
                x = x + dx; y = y - dy; z = z + atan_turn32[i];
            end
        end
        cq = clamp_to((x + 8192) >>> 14, 65536);
        sq = clamp_to((y + 8192) >>> 14, 65536);
        case (t[31:30])
            2'd0: begin c = cq;  s = sq;  end
            2'd1: begin c = -sq; s = cq;  end
            2'd2: begin c = -cq; s = -sq; end
            default: begin c = sq; s = -cq; end
        endcase
    endfunction

    function automatic vertex_t fan_vertex(input logic [12:0] idx);
        vertex_t           v;
        longint unsigned   seg, k, p, mask;
        longint            c, s, c20, s20, r;
        seg  = (segments_reg < 3) ? 3 : segments_reg;
        mask = (64'd1 << cfvg_pkg::ANGLE_BITS) - 1;
        v.pos_x = '0;
        v.pos_y = '0;
        v.red   = cfvg_pkg::ONE_Q16;
        v.green = cfvg_pkg::ONE_Q16;
        v.blue  = white_reg ? cfvg_pkg::ONE_Q16 : '0;
        if (idx != 0) begin
            k = (idx - 1) % seg;
            p = ((k << cfvg_pkg::ANGLE_BITS) / seg) & mask;
            r = radius_reg;
            cordic_sincos(p, c, s);
            v.pos_x = 17'(clamp_to((r * c + 32768) >>> 16, 65535));
            v.pos_y = 17'(clamp_to((r * s + 32768) >>> 16, 65535));
            if (!white_reg) begin
                cordic_sincos((p * cfvg_pkg::GREEN_MULT) & mask, c20, s20);
                v.red   = 17'((c * c + 32768) >>> 16);
                v.green = 17'((s20 * s20 + 32768) >>> 16);
                v.blue  = '0;
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        vertex_t want;
        vertex_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.pos_x = m_tdata[16:0];
            got.pos_y = m_tdata[33:17];
            got.red   = m_tdata[50:34];
            got.green = m_tdata[67:51];
            got.blue  = m_tdata[84:68];
            if (vertex_queue.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                err_cnt++;
            end else begin
                want = vertex_queue.pop_front();
                vertex_cnt++;
                if (got.pos_x !== want.pos_x) begin
                    $error("pos_x expected %0d actual %0d", want.pos_x, got.pos_x);
                    err_cnt++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $error("pos_y expected %0d actual %0d", want.pos_y, got.pos_y);
                    err_cnt++;
                end
                if (got.red !== want.red) begin
                    $error("color_red expected %0d actual %0d", want.red, got.red);
                    err_cnt++;
                end
                if (got.green !== want.green) begin
                    $error("color_green expected %0d actual %0d", want.green, got.green);
                    err_cnt++;
                end
                if (got.blue !== want.blue) begin
                    $error("color_blue expected %0d actual %0d", want.blue, got.blue);
                    err_cnt++;
                end
            end
        end
    end

    // Result side: random stall bursts, and one long hold-off on demand.
    initial begin
        int n;
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                n = 0;
                while (n < 300) begin
                    @(posedge aclk);
                    n++;
                end
                m_tready <= 1'b1;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(posedge aclk);
            end
        end
    end

    task automatic send_vertex(input logic [12:0] idx);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        vertex_queue.push_back(fan_vertex(idx));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (vertex_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_cnt++;
        case (index)
            cfvg_pkg::REG_SEGMENTS:   segments_reg = value[12:0];
            cfvg_pkg::REG_RADIUS:     radius_reg   = value;
            cfvg_pkg::REG_WHITE_MODE: white_reg    = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] seg, input logic [15:0] rad,
                             input logic white);
        drain();
        write_reg(cfvg_pkg::REG_SEGMENTS, seg);
        write_reg(cfvg_pkg::REG_RADIUS, rad);
        write_reg(cfvg_pkg::REG_WHITE_MODE, {15'd0, white});
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [12:0] pick_index();
        int unsigned seg;
        seg = (segments_reg < 3) ? 3 : segments_reg;
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'($urandom_range(0, 8191));
            default: return 13'($urandom_range(1, seg + 1));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_vertex(13'd0);
        send_vertex(13'd1);
        send_vertex(13'd17);
        send_vertex(13'd33);
        send_vertex(13'd64);
        send_vertex(13'd65);
        send_vertex(13'd8191);
    endtask

    task automatic test_extremes();
        configure(16'd0, 16'd65535, 1'b0);
        for (int i = 0; i < 5; i++) send_vertex(13'(i));
        send_vertex(13'd4097);
        configure(16'd4096, 16'd0, 1'b1);
        send_vertex(13'd0);
        send_vertex(13'd1);
        send_vertex(13'd1025);
        send_vertex(13'd4097);
        configure(16'hFFFF, 16'd65535, 1'b0);
        send_vertex(13'd8191);
        send_vertex(13'd4096);
        send_vertex(13'd2048);
    endtask

    task automatic test_random_settings();
        logic [15:0] seg_set[5] = '{16'd3, 16'd7, 16'd64, 16'd1000, 16'd4096};
        for (int ph = 0; ph < 5; ph++) begin
            configure(seg_set[ph], 16'($urandom_range(0, 65535)), ph[0]);
            repeat (80) send_vertex(pick_index());
        end
    endtask

    task automatic test_backpressure();
        configure(16'd12, 16'hFFFF, 1'b0);
        hold_req = 1'b1;
        repeat (100) send_vertex(pick_index());
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        configure(16'd2, 16'd1234, 1'b1);
        repeat (50) send_vertex(pick_index());
    endtask

    initial begin
        err_cnt      = 0;
        vertex_cnt   = 0;
        cfg_cnt      = 0;
        cycle_cnt    = 0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        segments_reg = cfvg_pkg::SEG_RESET;
        radius_reg   = cfvg_pkg::RAD_RESET;
        white_reg    = 1'b0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_extremes();
        test_random_settings();
        test_backpressure();
        test_no_idle();
        drain();

        $display("Checked %0d vertices over %0d register writes.", vertex_cnt, cfg_cnt);
        $display("Settings covered segment counts 0 to 8191, radius 0 and full, both color modes.");
        if (err_cnt == 0 && vertex_queue.size() == 0) begin
            $display("** circle_fan_vertex_generator: PASSED **");
        end else begin
            $display("** circle_fan_vertex_generator: FAILED **");
        end
        $finish;
    end

endmodule
